// ===== hw/rtl/vbdl_pkg.sv =====
`default_nettype none

package vbdl_pkg;

  // Field widths of the transfer channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned WORDS_W  = 17;
  localparam int unsigned BCOUNT_W = 19;

  // Byte format: seven data bits per byte, top bit flags a continuation.
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MORE_BIT   = 7;

  // Saturation limits of the byte counter and the word count.
  localparam logic [BCOUNT_W-1:0] BYTES_MAX = 19'h7FFFF;
  localparam logic [WORDS_W-1:0]  WORDS_MAX = 17'h1FFFF;

  // Configuration register map.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [0:0]  REG_DELTA_MODE = 1'b0;
  localparam logic        DELTA_MODE_RESET = 1'b1;

  // One result item.
  typedef struct packed {
    logic [OUT_W-1:0]   value;
    logic               last_value;
    logic [WORDS_W-1:0] words_used;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vbyte_delta_list_decoder_core.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_byte[8], in_new_list[1], in_list_length[16]
// out_      output     out_valid/out_stall out_value[32], out_last_value[1], out_words_used[17]
// cfg (APB) input      psel/penable/pready paddr[3], pwdata[32], prdata[32], pwrite
//
// One byte is accepted per cycle when the result side keeps up; the varint
// shift-and-OR and the running-sum add sit in a single stage between the
// input register and the result register.
// Reset (rst_n low, synchronous) clears the list state and sets delta mode.
// A result stalled in the output register holds the decode stage only when
// that stage also has a result to deliver; bytes that emit nothing move on.

`default_nettype none

module vbyte_delta_list_decoder_core #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [vbdl_pkg::BYTE_W-1:0]         in_byte,
  input  wire logic                                in_new_list,
  input  wire logic [vbdl_pkg::LEN_W-1:0]          in_list_length,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [vbdl_pkg::OUT_W-1:0]               out_value,
  output logic                                     out_last_value,
  output logic [vbdl_pkg::WORDS_W-1:0]             out_words_used,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [vbdl_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [vbdl_pkg::DATA_W-1:0]         pwdata,
  output logic [vbdl_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready
);

  // Configuration register.
  logic delta_mode_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == vbdl_pkg::REG_DELTA_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= vbdl_pkg::DELTA_MODE_RESET;
    end else if (cfg_wr) begin
      delta_mode_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == vbdl_pkg::REG_DELTA_MODE) begin
      prdata[0] = delta_mode_r;
    end
  end

  // Input register.
  logic                         s1_valid_r;
  logic [vbdl_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                         s1_new_list_r;
  logic [vbdl_pkg::LEN_W-1:0]   s1_len_r;

  // List state.
  logic [VALUE_WIDTH-1:0]        acc_r;
  logic [VALUE_WIDTH-1:0]        sum_r;
  logic [COUNT_WIDTH-1:0]        rem_r;
  logic [vbdl_pkg::BCOUNT_W-1:0] bc_r;

  // Result register.
  logic                 out_valid_r;
  vbdl_pkg::result_t    out_r;

  // Decode stage signals.
  logic                          s1_emit;
  logic                          s1_go;
  logic                          s1_fire;
  logic                          in_fire;
  logic [VALUE_WIDTH-1:0]        acc_base;
  logic [VALUE_WIDTH-1:0]        sum_base;
  logic [COUNT_WIDTH-1:0]        rem_base;
  logic [vbdl_pkg::BCOUNT_W-1:0] bc_base;
  logic [VALUE_WIDTH-1:0]        acc_shift;
  logic [VALUE_WIDTH-1:0]        sum_add;
  logic [VALUE_WIDTH-1:0]        result_val;
  logic [COUNT_WIDTH-1:0]        rem_dec;
  logic [vbdl_pkg::BCOUNT_W-1:0] bc_inc;
  logic [vbdl_pkg::BCOUNT_W:0]   bc_plus3;
  logic [vbdl_pkg::WORDS_W:0]    words_raw;
  logic [vbdl_pkg::WORDS_W-1:0]  words_sat;
  logic                          more;
  logic                          active;
  logic [VALUE_WIDTH-1:0]        acc_nxt;
  logic [VALUE_WIDTH-1:0]        sum_nxt;
  logic [COUNT_WIDTH-1:0]        rem_nxt;
  logic [vbdl_pkg::BCOUNT_W-1:0] bc_nxt;
  vbdl_pkg::result_t             res_nxt;

  // A list start clears the state before the same byte is decoded.
  always_comb begin
    if (s1_new_list_r) begin
      acc_base = '0;
      sum_base = '0;
      rem_base = COUNT_WIDTH'(s1_len_r);
      bc_base  = '0;
    end else begin
      acc_base = acc_r;
      sum_base = sum_r;
      rem_base = rem_r;
      bc_base  = bc_r;
    end
  end

  // Varint step, running sum and word count.
  always_comb begin
    active    = (rem_base != '0);
    more      = s1_byte_r[vbdl_pkg::MORE_BIT];
    acc_shift = {acc_base[VALUE_WIDTH-1-vbdl_pkg::GROUP_BITS:0],
                 s1_byte_r[vbdl_pkg::GROUP_BITS-1:0]};
    sum_add   = sum_base + acc_shift;
    rem_dec   = rem_base - COUNT_WIDTH'(1);
    bc_inc    = (bc_base < vbdl_pkg::BYTES_MAX) ? bc_base + 1'b1 : bc_base;
    bc_plus3  = {1'b0, bc_inc} + (vbdl_pkg::BCOUNT_W + 1)'(3);
    words_raw = bc_plus3[vbdl_pkg::BCOUNT_W:2];
    words_sat = words_raw[vbdl_pkg::WORDS_W] ? vbdl_pkg::WORDS_MAX
                                             : words_raw[vbdl_pkg::WORDS_W-1:0];
    result_val = delta_mode_r ? sum_add : acc_shift;

    acc_nxt = acc_base;
    sum_nxt = sum_base;
    rem_nxt = rem_base;
    bc_nxt  = bc_base;
    s1_emit = 1'b0;
    if (active) begin
      bc_nxt = bc_inc;
      if (more) begin
        acc_nxt = acc_shift;
      end else begin
        s1_emit = 1'b1;
        acc_nxt = '0;
        rem_nxt = rem_dec;
        if (delta_mode_r) begin
          sum_nxt = sum_add;
        end
      end
    end

    res_nxt.value      = vbdl_pkg::OUT_W'(result_val);
    res_nxt.last_value = (rem_dec == '0);
    res_nxt.words_used = (rem_dec == '0) ? words_sat : '0;
  end

  // Flow control: only a byte that emits waits on the result register.
  assign s1_go    = !s1_emit || !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  // Input register control and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r     <= in_byte;
      s1_new_list_r <= in_new_list;
      s1_len_r      <= in_list_length;
    end
  end

  // List state updates as each byte leaves the decode stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sum_r <= '0;
      rem_r <= '0;
      bc_r  <= '0;
    end else if (s1_fire) begin
      acc_r <= acc_nxt;
      sum_r <= sum_nxt;
      rem_r <= rem_nxt;
      bc_r  <= bc_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_r.value;
  assign out_last_value = out_r.last_value;
  assign out_words_used = out_r.words_used;

  // The final value of a list always reports at least one word.
  a_last_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_value |-> out_words_used != '0)
    else $error("last value reported with zero words");

  // Only the final value carries a word count.
  a_words_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_value |-> out_words_used == '0)
    else $error("word count on a value that is not the last");

  // A completed value leaves the accumulator clear.
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_emit |=> acc_r == '0)
    else $error("accumulator not cleared after a value");

  // Emitting the last value of a list exhausts the remaining count.
  a_list_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_emit && res_nxt.last_value |=> rem_r == '0)
    else $error("values remain after the last value");

endmodule

`default_nettype wire
